>>> rtl/mtc_pkg.sv
// shared types, character codes and morse tables for the morse text codec
`default_nettype none

package mtc_pkg;

  localparam int CHAR_W   = 8;
  localparam int MAX_OUT  = 5;
  localparam int CNT_W    = 3;
  localparam int NUM_LTR  = 26;
  localparam int PAT_W    = 4;
  localparam int LEN_W    = 3;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_MASK = 8'hdf;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  typedef logic [CHAR_W-1:0] char_t;

  // decode state carried between beats
  typedef struct packed {
    logic              decode_mode;
    logic [PAT_W-1:0]  code_pattern;
    logic [LEN_W-1:0]  code_length;
    logic              code_invalid;
    logic              odd_space_seen;
  } codec_state_t;

  // per letter: {length, pattern}, symbol k at bit k, dash = 1
  localparam logic [LEN_W+PAT_W-1:0] MORSE_TAB [NUM_LTR] = '{
    {3'd2, 4'd2},  {3'd4, 4'd1},  {3'd4, 4'd5},  {3'd3, 4'd1},  {3'd1, 4'd0},
    {3'd4, 4'd4},  {3'd3, 4'd3},  {3'd4, 4'd0},  {3'd2, 4'd0},  {3'd4, 4'd14},
    {3'd3, 4'd5},  {3'd4, 4'd2},  {3'd2, 4'd3},  {3'd2, 4'd1},  {3'd3, 4'd7},
    {3'd4, 4'd6},  {3'd4, 4'd11}, {3'd3, 4'd2},  {3'd3, 4'd0},  {3'd1, 4'd1},
    {3'd3, 4'd4},  {3'd4, 4'd8},  {3'd3, 4'd6},  {3'd4, 4'd9},  {3'd4, 4'd13},
    {3'd4, 4'd3}
  };

  // lowercase letter for a pending code, CH_NONE when empty, invalid or unknown
  function automatic char_t lookup_letter(input codec_state_t st);
    char_t res;
    res = CH_NONE;
    if (!st.code_invalid && st.code_length != '0) begin
      for (int i = 0; i < NUM_LTR; i++) begin
        if (MORSE_TAB[i] == {st.code_length, st.code_pattern}) begin
          res = CH_LO_A + CHAR_W'(i);
        end
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/morse_text_codec.sv
// top level of the morse text codec: step logic, state and result buffer
//
// input stream (s_*): one text character per beat. s_tdata is the character,
// s_tuser marks the first character of a text (it picks the mode: '.' or '-'
// decodes, anything else encodes), s_tlast marks the last character.
// output stream (m_*): one character per beat ('.', '-', space or a lowercase
// letter); m_tlast flags the final beat caused by one input character.
// an accepted character is worked out in the same cycle and its zero to five
// result characters land in a shift buffer; the first one is on m_* the cycle
// after acceptance, the rest follow one per cycle while m_tready is high.
// throughput: the next input is taken when the last result of the current one
// leaves, so in encode mode the output port sets the pace; characters that
// produce nothing (symbols while decoding) go at one per cycle.
// s_tready is high when the buffer is empty or its last beat leaves this
// cycle, so the next character enters as the previous run's last beat leaves.
// a stalled receiver holds the current beat and keeps s_tready low until
// the final beat of the run can leave.
// reset (rst, synchronous) empties the buffer and returns to encode mode
// with no pending code.
`default_nettype none

module morse_text_codec (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire mtc_pkg::char_t       s_tdata,   // [7:0] char_code
  input  wire logic                 s_tuser,   // [0] start_of_text
  input  wire logic                 s_tlast,   // end_of_text
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output mtc_pkg::char_t            m_tdata,   // [7:0] out_char
  output logic                      m_tlast    // last_of_run
);
  import mtc_pkg::*;

  codec_state_t     state;
  codec_state_t     state_next;
  char_t            res_list [MAX_OUT];
  logic [CNT_W-1:0] res_count;

  // result buffer: slot 0 faces the output, shifts down on each beat
  char_t            buf_q [MAX_OUT];
  logic [CNT_W-1:0] remaining;

  logic in_beat;
  logic out_beat;

  mtc_step u_step (
    .char_code     (s_tdata),
    .start_of_text (s_tuser),
    .end_of_text   (s_tlast),
    .state         (state),
    .state_next    (state_next),
    .res_list      (res_list),
    .res_count     (res_count)
  );

  assign m_tvalid = (remaining != '0);
  assign m_tdata  = buf_q[0];
  assign m_tlast  = (remaining == 3'd1);
  assign out_beat = m_tvalid && m_tready;
  // room once the buffer is empty or its final beat leaves now
  assign s_tready = (remaining == '0) || (m_tlast && m_tready);
  assign in_beat  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      remaining <= '0;
    end else begin
      if (in_beat) begin
        state     <= state_next;
        remaining <= res_count;
      end else if (out_beat) begin
        remaining <= remaining - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      for (int i = 0; i < MAX_OUT; i++) begin
        buf_q[i] <= res_list[i];
      end
    end else if (out_beat) begin
      for (int i = 0; i < MAX_OUT - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mtc_step.sv
// one text character through the codec: result list and next decode state
`default_nettype none

module mtc_step (
  input  wire mtc_pkg::char_t        char_code,
  input  wire logic                  start_of_text,
  input  wire logic                  end_of_text,
  input  wire mtc_pkg::codec_state_t state,
  output mtc_pkg::codec_state_t      state_next,
  output mtc_pkg::char_t             res_list [mtc_pkg::MAX_OUT],
  output logic [mtc_pkg::CNT_W-1:0]  res_count
);
  import mtc_pkg::*;

  codec_state_t st;
  char_t        up;
  char_t        ltr;
  logic [4:0]   ltr_idx;
  logic [LEN_W+PAT_W-1:0] ent;
  logic         is_letter;
  logic         is_sym;
  logic [CNT_W-1:0] n;

  always_comb begin
    st  = state;
    n   = '0;
    ltr = CH_NONE;
    for (int i = 0; i < MAX_OUT; i++) begin
      res_list[i] = CH_SPACE;
    end

    is_sym = (char_code == CH_DOT) || (char_code == CH_DASH);
    if (start_of_text) begin
      st = '0;
      st.decode_mode = is_sym;
    end

    up      = char_code & CASE_MASK;
    ltr_idx = 5'(up - CH_UP_A);
    ent     = MORSE_TAB[ltr_idx < 5'(NUM_LTR) ? ltr_idx : 5'd0];
    is_letter = (char_code inside {[CH_UP_A:CH_UP_Z]}) ||
                (char_code inside {[CH_LO_A:CH_LO_Z]});

    if (!st.decode_mode) begin
      if (is_letter) begin
        for (int k = 0; k < PAT_W; k++) begin
          if (LEN_W'(k) < ent[LEN_W+PAT_W-1:PAT_W]) begin
            res_list[n] = ent[k] ? CH_DASH : CH_DOT;
            n = n + 3'd1;
          end
        end
        res_list[n] = CH_SPACE;
        n = n + 3'd1;
      end else if (char_code == CH_SPACE) begin
        n = 3'd2;
      end else begin
        n = 3'd1;
      end
    end else begin
      if (char_code == CH_SPACE) begin
        if (st.odd_space_seen) begin
          res_list[n] = CH_SPACE;
          n = n + 3'd1;
          st.odd_space_seen = 1'b0;
        end else begin
          ltr = lookup_letter(st);
          if (ltr != CH_NONE) begin
            res_list[n] = ltr;
            n = n + 3'd1;
          end
          st.code_pattern   = '0;
          st.code_length    = '0;
          st.code_invalid   = 1'b0;
          st.odd_space_seen = 1'b1;
        end
      end else begin
        st.odd_space_seen = 1'b0;
        if (is_sym && st.code_length < LEN_W'(PAT_W)) begin
          if (char_code == CH_DASH) begin
            st.code_pattern[st.code_length[1:0]] = 1'b1;
          end
          st.code_length = st.code_length + 3'd1;
        end else begin
          st.code_invalid = 1'b1;
        end
      end
      if (end_of_text) begin
        // flush pending letter, then close with a space
        ltr = lookup_letter(st);
        if (ltr != CH_NONE) begin
          res_list[n] = ltr;
          n = n + 3'd1;
        end
        res_list[n] = CH_SPACE;
        n = n + 3'd1;
        st.code_pattern   = '0;
        st.code_length    = '0;
        st.code_invalid   = 1'b0;
        st.odd_space_seen = 1'b0;
      end
    end

    state_next = st;
    res_count  = n;
  end

endmodule

`default_nettype wire

>>> rtl/mtc_checker.sv
// port-level checks for the morse text codec and their bind
`default_nettype none

module mtc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // only morse symbols, spaces and lowercase letters come out
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == 8'h2e || m_tdata == 8'h2d || m_tdata == 8'h20 ||
                  (m_tdata >= 8'h61 && m_tdata <= 8'h7a)))
    else $error("unexpected output character");

  // no new character is taken while more than one beat of a run is pending
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken in the middle of a run");

  // reset empties the result buffer
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind morse_text_codec mtc_checker u_mtc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
